FILE: src/ccimp_pkg.sv
// ----------------------------------------------------------------------------
// ccimp_pkg
// Widths, constants and the work item type shared by the collision pipeline.
// ----------------------------------------------------------------------------
package ccimp_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int NORM_FRAC = 30;

    localparam int MAG_W  = WORD_BITS - 1;
    localparam int XW     = 2 * WORD_BITS;
    localparam int SQ_W   = 2 * WORD_BITS - 2;
    localparam int D2_W   = SQ_W + 1;
    localparam int DIST_W = WORD_BITS;
    localparam int REST_W = 17;
    localparam int ONEPE_W = REST_W + 1;
    localparam int FAC_W  = ONEPE_W;
    localparam int NUM_W  = ONEPE_W + MAG_W;
    localparam int MSUM_W = WORD_BITS;
    localparam int NMAG_W = NORM_FRAC + 1;
    localparam int DOT_W  = WORD_BITS + 3;
    localparam int K_W    = DOT_W - 1 + FAC_W - FRAC_BITS;
    localparam int RES_W  = K_W + 3;

    localparam int SQRT_STAGES = DIST_W;
    localparam int DIV_STAGES  = (NORM_FRAC > FAC_W) ? NORM_FRAC : FAC_W;
    localparam int BACK_STAGES = 7;

    localparam int IN_BITS     = 6 * WORD_BITS + 3 * MAG_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 4 * WORD_BITS;
    localparam int OUT_TUSER_W = 2;

    localparam logic [REST_W-1:0] REST_RESET = REST_W'(52429);

    typedef struct packed {
        logic signed [WORD_BITS-1:0] rel_x;
        logic signed [WORD_BITS-1:0] rel_y;
        logic signed [WORD_BITS-1:0] vel_a_x;
        logic signed [WORD_BITS-1:0] vel_a_y;
        logic signed [WORD_BITS-1:0] vel_b_x;
        logic signed [WORD_BITS-1:0] vel_b_y;
        logic [MAG_W-1:0]            mass_a;
        logic [MAG_W-1:0]            mass_b;
        logic [MAG_W-1:0]            contact_distance;
        logic                        skip_pair;
        logic [WORD_BITS-1:0]        mag_x;
        logic [WORD_BITS-1:0]        mag_y;
        logic [SQ_W-1:0]             sq_x;
        logic [SQ_W-1:0]             sq_y;
        logic [SQ_W-1:0]             sq_c;
        logic [NUM_W-1:0]            num_a;
        logic [NUM_W-1:0]            num_b;
        logic [MSUM_W-1:0]           msum;
        logic [D2_W-1:0]             d2;
        logic                        touch;
        logic [DIST_W-1:0]           distance;
        logic [NMAG_W-1:0]           nmag_x;
        logic [NMAG_W-1:0]           nmag_y;
        logic [FAC_W-1:0]            fa;
        logic [FAC_W-1:0]            fb;
    } t_work;

endpackage

FILE: src/ccimp_front.sv
// ----------------------------------------------------------------------------
// ccimp_front
// Squares, mass products and the contact test, two register stages.
// ----------------------------------------------------------------------------
module ccimp_front
    import ccimp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_work             i_item,
    input  logic [REST_W-1:0] i_restitution,
    output logic              o_valid,
    output t_work             o_item
);

    localparam logic [ONEPE_W-1:0] ONE_Q = ONEPE_W'(1) << FRAC_BITS;

    t_work r_s1, n_s1, r_s2, n_s2;
    logic  r_v1, r_v2;

    logic [WORD_BITS-1:0] ux, uy, mx, my;
    logic [XW-1:0]        fx, fy;
    logic [ONEPE_W-1:0]   onepe;

    always_comb begin
        ux    = i_item.rel_x;
        uy    = i_item.rel_y;
        mx    = ux[WORD_BITS-1] ? (~ux + 1'b1) : ux;
        my    = uy[WORD_BITS-1] ? (~uy + 1'b1) : uy;
        fx    = XW'(mx) * XW'(mx);
        fy    = XW'(my) * XW'(my);
        onepe = ONE_Q + ONEPE_W'(i_restitution);
        n_s1        = i_item;
        n_s1.mag_x  = mx;
        n_s1.mag_y  = my;
        n_s1.sq_x   = (|fx[XW-1:SQ_W]) ? '1 : fx[SQ_W-1:0];
        n_s1.sq_y   = (|fy[XW-1:SQ_W]) ? '1 : fy[SQ_W-1:0];
        n_s1.sq_c   = SQ_W'(i_item.contact_distance) * SQ_W'(i_item.contact_distance);
        n_s1.num_a  = NUM_W'(onepe) * NUM_W'(i_item.mass_b);
        n_s1.num_b  = NUM_W'(onepe) * NUM_W'(i_item.mass_a);
        n_s1.msum   = MSUM_W'(i_item.mass_a) + MSUM_W'(i_item.mass_b);
    end

    always_comb begin
        n_s2       = r_s1;
        n_s2.d2    = D2_W'(r_s1.sq_x) + D2_W'(r_s1.sq_y);
        n_s2.touch = !r_s1.skip_pair && (n_s2.d2 < D2_W'(r_s1.sq_c));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_s2;

endmodule

FILE: src/ccimp_sqrt.sv
// ----------------------------------------------------------------------------
// ccimp_sqrt
// Integer square root of the squared distance, one result bit per stage.
// ----------------------------------------------------------------------------
module ccimp_sqrt
    import ccimp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_work i_item,
    output logic  o_valid,
    output t_work o_item
);

    localparam int N = SQRT_STAGES;

    logic [XW-1:0] r_x  [0:N-1];
    logic [XW-1:0] r_r  [0:N-1];
    t_work         r_it [0:N-1];
    logic          r_v  [0:N-1];

    genvar k;
    for (k = 0; k < N; k++) begin : g_step
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (N - 1 - k));
        logic [XW-1:0] x_in, r_in, trial;
        t_work         it_in;
        logic          v_in;

        if (k == 0) begin : g_first
            assign x_in  = XW'(i_item.d2);
            assign r_in  = '0;
            assign it_in = i_item;
            assign v_in  = i_valid;
        end else begin : g_next
            assign x_in  = r_x[k-1];
            assign r_in  = r_r[k-1];
            assign it_in = r_it[k-1];
            assign v_in  = r_v[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (x_in >= trial) begin
                    r_x[k] <= x_in - trial;
                    r_r[k] <= (r_in >> 1) + BIT;
                end else begin
                    r_x[k] <= x_in;
                    r_r[k] <= r_in >> 1;
                end
                r_it[k] <= it_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end
    end

    always_comb begin
        o_item          = r_it[N-1];
        o_item.distance = r_r[N-1][DIST_W-1:0];
    end

    assign o_valid = r_v[N-1];

    logic [XW+1:0] chk_lo, chk_hi, chk_d2;
    assign chk_lo = (XW+2)'(o_item.distance) * (XW+2)'(o_item.distance);
    assign chk_hi = ((XW+2)'(o_item.distance) + 1'b1) * ((XW+2)'(o_item.distance) + 1'b1);
    assign chk_d2 = (XW+2)'(o_item.d2);

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (chk_lo <= chk_d2) && (chk_hi > chk_d2))
        else $error("distance is not the floor square root");

endmodule

FILE: src/ccimp_div.sv
// ----------------------------------------------------------------------------
// ccimp_div
// Unit normal and mass factor quotients, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ccimp_div
    import ccimp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_work i_item,
    output logic  o_valid,
    output t_work o_item
);

    localparam int N = DIV_STAGES;
    localparam logic [NMAG_W-1:0] NORM_ONE = NMAG_W'(1) << NORM_FRAC;

    function automatic logic [WORD_BITS:0] div_step(
        input logic [WORD_BITS-1:0] rem,
        input logic [WORD_BITS-1:0] dvs,
        input logic                 bit_in
    );
        logic [WORD_BITS:0] t;
        logic [WORD_BITS:0] s;
        t = {rem, bit_in};
        s = t - {1'b0, dvs};
        if (t >= {1'b0, dvs}) begin
            div_step = {s[WORD_BITS-1:0], 1'b1};
        end else begin
            div_step = {t[WORD_BITS-1:0], 1'b0};
        end
    endfunction

    logic [WORD_BITS-1:0] r_rx [0:N-1];
    logic [WORD_BITS-1:0] r_ry [0:N-1];
    logic [NORM_FRAC-1:0] r_qx [0:N-1];
    logic [NORM_FRAC-1:0] r_qy [0:N-1];
    logic [WORD_BITS-1:0] r_ra [0:N-1];
    logic [WORD_BITS-1:0] r_rb [0:N-1];
    logic [FAC_W-1:0]     r_qa [0:N-1];
    logic [FAC_W-1:0]     r_qb [0:N-1];
    t_work                r_it [0:N-1];
    logic                 r_v  [0:N-1];

    genvar k;
    for (k = 0; k < N; k++) begin : g_step
        logic [WORD_BITS-1:0] rx_in, ry_in, ra_in, rb_in;
        logic [NORM_FRAC-1:0] qx_in, qy_in;
        logic [FAC_W-1:0]     qa_in, qb_in;
        logic [WORD_BITS-1:0] rx_nx, ry_nx, ra_nx, rb_nx;
        logic [NORM_FRAC-1:0] qx_nx, qy_nx;
        logic [FAC_W-1:0]     qa_nx, qb_nx;
        t_work                it_in;
        logic                 v_in;

        if (k == 0) begin : g_first
            assign rx_in = i_item.mag_x;
            assign ry_in = i_item.mag_y;
            assign ra_in = WORD_BITS'(i_item.num_a[NUM_W-1:FAC_W]);
            assign rb_in = WORD_BITS'(i_item.num_b[NUM_W-1:FAC_W]);
            assign qx_in = '0;
            assign qy_in = '0;
            assign qa_in = '0;
            assign qb_in = '0;
            assign it_in = i_item;
            assign v_in  = i_valid;
        end else begin : g_next
            assign rx_in = r_rx[k-1];
            assign ry_in = r_ry[k-1];
            assign ra_in = r_ra[k-1];
            assign rb_in = r_rb[k-1];
            assign qx_in = r_qx[k-1];
            assign qy_in = r_qy[k-1];
            assign qa_in = r_qa[k-1];
            assign qb_in = r_qb[k-1];
            assign it_in = r_it[k-1];
            assign v_in  = r_v[k-1];
        end

        if (k < NORM_FRAC) begin : g_norm
            logic [WORD_BITS:0] sx, sy;
            assign sx    = div_step(rx_in, it_in.distance, 1'b0);
            assign sy    = div_step(ry_in, it_in.distance, 1'b0);
            assign rx_nx = sx[WORD_BITS:1];
            assign ry_nx = sy[WORD_BITS:1];
            assign qx_nx = {qx_in[NORM_FRAC-2:0], sx[0]};
            assign qy_nx = {qy_in[NORM_FRAC-2:0], sy[0]};
        end else begin : g_norm_hold
            assign rx_nx = rx_in;
            assign ry_nx = ry_in;
            assign qx_nx = qx_in;
            assign qy_nx = qy_in;
        end

        if (k < FAC_W) begin : g_mass
            logic [WORD_BITS:0] sa, sb;
            assign sa    = div_step(ra_in, it_in.msum, it_in.num_a[FAC_W-1-k]);
            assign sb    = div_step(rb_in, it_in.msum, it_in.num_b[FAC_W-1-k]);
            assign ra_nx = sa[WORD_BITS:1];
            assign rb_nx = sb[WORD_BITS:1];
            assign qa_nx = {qa_in[FAC_W-2:0], sa[0]};
            assign qb_nx = {qb_in[FAC_W-2:0], sb[0]};
        end else begin : g_mass_hold
            assign ra_nx = ra_in;
            assign rb_nx = rb_in;
            assign qa_nx = qa_in;
            assign qb_nx = qb_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rx[k] <= rx_nx;
                r_ry[k] <= ry_nx;
                r_qx[k] <= qx_nx;
                r_qy[k] <= qy_nx;
                r_ra[k] <= ra_nx;
                r_rb[k] <= rb_nx;
                r_qa[k] <= qa_nx;
                r_qb[k] <= qb_nx;
                r_it[k] <= it_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end
    end

    always_comb begin
        o_item = r_it[N-1];
        if (o_item.distance == '0) begin
            o_item.nmag_x = '0;
            o_item.nmag_y = '0;
        end else begin
            o_item.nmag_x = (o_item.mag_x >= o_item.distance) ? NORM_ONE
                                                              : NMAG_W'(r_qx[N-1]);
            o_item.nmag_y = (o_item.mag_y >= o_item.distance) ? NORM_ONE
                                                              : NMAG_W'(r_qy[N-1]);
        end
        if (o_item.msum == '0) begin
            o_item.fa = '0;
            o_item.fb = '0;
        end else begin
            o_item.fa = r_qa[N-1];
            o_item.fb = r_qb[N-1];
        end
    end

    assign o_valid = r_v[N-1];

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.nmag_x <= NORM_ONE) && (o_item.nmag_y <= NORM_ONE))
        else $error("normal component above one");

endmodule

FILE: src/ccimp_back.sv
// ----------------------------------------------------------------------------
// ccimp_back
// Approach test, impulse scaling and velocity update with saturation.
// ----------------------------------------------------------------------------
module ccimp_back
    import ccimp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_work                  i_item,
    output logic                   o_valid,
    output logic [OUT_TDATA_W-1:0] o_vel,
    output logic                   o_touch,
    output logic                   o_applied
);

    localparam int PW  = WORD_BITS + NMAG_W;
    localparam int PAW = DOT_W - 1 + FAC_W;
    localparam int QW  = NMAG_W + K_W;
    localparam logic signed [RES_W-1:0] SAT_HI =
        {{(RES_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic [WORD_BITS-1:0] sat_w(input logic signed [RES_W-1:0] v);
        if (v > SAT_HI) begin
            sat_w = {1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (v < SAT_LO) begin
            sat_w = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            sat_w = v[WORD_BITS-1:0];
        end
    endfunction

    function automatic logic [RES_W-1:0] upd(
        input logic signed [WORD_BITS-1:0] v,
        input logic [K_W:0]                d,
        input logic                        add
    );
        logic signed [RES_W-1:0] ev;
        logic signed [RES_W-1:0] ed;
        ev = RES_W'(v);
        ed = RES_W'(d);
        upd = add ? (ev + ed) : (ev - ed);
    endfunction

    logic [BACK_STAGES-1:0] r_v;

    // stage 1: relative velocity magnitudes
    t_work                r1_it;
    logic [WORD_BITS-1:0] r1_mx, r1_my;
    logic                 r1_sx, r1_sy;
    logic [WORD_BITS:0]   dvx, dvy, adx, ady;

    always_comb begin
        dvx = {i_item.vel_a_x[WORD_BITS-1], i_item.vel_a_x}
            - {i_item.vel_b_x[WORD_BITS-1], i_item.vel_b_x};
        dvy = {i_item.vel_a_y[WORD_BITS-1], i_item.vel_a_y}
            - {i_item.vel_b_y[WORD_BITS-1], i_item.vel_b_y};
        adx = dvx[WORD_BITS] ? (~dvx + 1'b1) : dvx;
        ady = dvy[WORD_BITS] ? (~dvy + 1'b1) : dvy;
    end

    // stage 2: products with the normal
    t_work         r2_it;
    logic [PW-1:0] r2_px, r2_py;
    logic          r2_sx, r2_sy;

    // stage 3: dot product
    t_work                   r3_it;
    logic [DOT_W-2:0]        r3_dmag;
    logic                    r3_dneg;
    logic                    r3_appl;
    logic signed [DOT_W-1:0] tx, ty, dot;

    always_comb begin
        tx  = DOT_W'(r2_px[PW-1:NORM_FRAC]);
        ty  = DOT_W'(r2_py[PW-1:NORM_FRAC]);
        dot = (r2_sx ? -tx : tx) + (r2_sy ? -ty : ty);
    end

    // stage 4: dot times mass factors
    t_work          r4_it;
    logic [PAW-1:0] r4_pa, r4_pb;
    logic           r4_dneg, r4_appl;

    // stage 5: scaled impulses
    t_work          r5_it;
    logic [K_W-1:0] r5_ka, r5_kb;
    logic           r5_dneg, r5_appl;

    // stage 6: impulse times normal
    t_work         r6_it;
    logic [QW-1:0] r6_qax, r6_qay, r6_qbx, r6_qby;
    logic          r6_dneg, r6_appl;

    // stage 7: output register
    logic [OUT_TDATA_W-1:0] r7_vel, n7_vel;
    logic                   r7_touch, r7_appl;
    logic                   nx_neg, ny_neg;

    always_comb begin
        nx_neg = r6_it.rel_x[WORD_BITS-1] ^ r6_dneg;
        ny_neg = r6_it.rel_y[WORD_BITS-1] ^ r6_dneg;
        if (r6_appl) begin
            n7_vel = {sat_w(upd(r6_it.vel_b_y, r6_qby[QW-1:NORM_FRAC], !ny_neg)),
                      sat_w(upd(r6_it.vel_b_x, r6_qbx[QW-1:NORM_FRAC], !nx_neg)),
                      sat_w(upd(r6_it.vel_a_y, r6_qay[QW-1:NORM_FRAC], ny_neg)),
                      sat_w(upd(r6_it.vel_a_x, r6_qax[QW-1:NORM_FRAC], nx_neg))};
        end else begin
            n7_vel = {r6_it.vel_b_y, r6_it.vel_b_x, r6_it.vel_a_y, r6_it.vel_a_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_it    <= i_item;
            r1_mx    <= adx[WORD_BITS-1:0];
            r1_my    <= ady[WORD_BITS-1:0];
            r1_sx    <= dvx[WORD_BITS] ^ i_item.rel_x[WORD_BITS-1];
            r1_sy    <= dvy[WORD_BITS] ^ i_item.rel_y[WORD_BITS-1];

            r2_it    <= r1_it;
            r2_px    <= PW'(r1_mx) * PW'(r1_it.nmag_x);
            r2_py    <= PW'(r1_my) * PW'(r1_it.nmag_y);
            r2_sx    <= r1_sx;
            r2_sy    <= r1_sy;

            r3_it    <= r2_it;
            r3_dmag  <= dot[DOT_W-1] ? (DOT_W-1)'(-dot) : dot[DOT_W-2:0];
            r3_dneg  <= dot[DOT_W-1];
            r3_appl  <= r2_it.touch && (dot[DOT_W-1] || (dot == '0));

            r4_it    <= r3_it;
            r4_pa    <= PAW'(r3_dmag) * PAW'(r3_it.fa);
            r4_pb    <= PAW'(r3_dmag) * PAW'(r3_it.fb);
            r4_dneg  <= r3_dneg;
            r4_appl  <= r3_appl;

            r5_it    <= r4_it;
            r5_ka    <= r4_pa[PAW-1:FRAC_BITS];
            r5_kb    <= r4_pb[PAW-1:FRAC_BITS];
            r5_dneg  <= r4_dneg;
            r5_appl  <= r4_appl;

            r6_it    <= r5_it;
            r6_qax   <= QW'(r5_it.nmag_x) * QW'(r5_ka);
            r6_qay   <= QW'(r5_it.nmag_y) * QW'(r5_ka);
            r6_qbx   <= QW'(r5_it.nmag_x) * QW'(r5_kb);
            r6_qby   <= QW'(r5_it.nmag_y) * QW'(r5_kb);
            r6_dneg  <= r5_dneg;
            r6_appl  <= r5_appl;

            r7_vel   <= n7_vel;
            r7_touch <= r6_it.touch;
            r7_appl  <= r6_appl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[BACK_STAGES-2:0], i_valid};
        end
    end

    assign o_valid   = r_v[BACK_STAGES-1];
    assign o_vel     = r7_vel;
    assign o_touch   = r7_touch;
    assign o_applied = r7_appl;

endmodule

FILE: src/circle_collision_impulse_core.sv
// ----------------------------------------------------------------------------
// circle_collision_impulse_core
// Pipelined restitution impulse for one pair of circular bodies per cycle.
//
//   port group   dir  contents
//   s_t*         in   one body pair; tuser = skip_pair
//   m_t*         out  both new velocities; tuser = touching, impulse_applied
//   cfg_wr_*     in   restitution, unsigned Q1.16
//
// One pair enters per cycle unless the output stalls; the path is the front,
// square root (one result bit per stage), divider and back stages.
// Reset clears only valid bits and restitution (0.8); no clearing pass.
// A stall on the output freezes every stage; o_s_tready drops in that cycle.
// ----------------------------------------------------------------------------
module circle_collision_impulse_core
    import ccimp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // rel_x, rel_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y, mass_a, mass_b,
    // contact_distance, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // skip_pair
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // touching, impulse_applied
    output logic [OUT_TUSER_W-1:0] o_m_tuser,
    input  logic                   i_cfg_wr_en,
    input  logic [REST_W-1:0]      i_cfg_wr_data
);

    localparam int OFS_MA = 6 * WORD_BITS;
    localparam int OFS_MB = OFS_MA + MAG_W;
    localparam int OFS_CD = OFS_MB + MAG_W;

    logic [REST_W-1:0] r_restitution;
    logic              en;
    t_work             in_item, f_item, s_item, d_item;
    logic              f_v, s_v, d_v;
    logic              b_touch, b_appl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= REST_RESET;
        end else if (i_cfg_wr_en) begin
            r_restitution <= i_cfg_wr_data;
        end
    end

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    always_comb begin
        in_item                  = '0;
        in_item.rel_x            = i_s_tdata[0 +: WORD_BITS];
        in_item.rel_y            = i_s_tdata[WORD_BITS +: WORD_BITS];
        in_item.vel_a_x          = i_s_tdata[2*WORD_BITS +: WORD_BITS];
        in_item.vel_a_y          = i_s_tdata[3*WORD_BITS +: WORD_BITS];
        in_item.vel_b_x          = i_s_tdata[4*WORD_BITS +: WORD_BITS];
        in_item.vel_b_y          = i_s_tdata[5*WORD_BITS +: WORD_BITS];
        in_item.mass_a           = i_s_tdata[OFS_MA +: MAG_W];
        in_item.mass_b           = i_s_tdata[OFS_MB +: MAG_W];
        in_item.contact_distance = i_s_tdata[OFS_CD +: MAG_W];
        in_item.skip_pair        = i_s_tuser;
    end

    ccimp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_s_tvalid),
        .i_item        (in_item),
        .i_restitution (r_restitution),
        .o_valid       (f_v),
        .o_item        (f_item)
    );

    ccimp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_item  (f_item),
        .o_valid (s_v),
        .o_item  (s_item)
    );

    ccimp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_v),
        .i_item  (s_item),
        .o_valid (d_v),
        .o_item  (d_item)
    );

    ccimp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (d_v),
        .i_item    (d_item),
        .o_valid   (o_m_tvalid),
        .o_vel     (o_m_tdata),
        .o_touch   (b_touch),
        .o_applied (b_appl)
    );

    assign o_m_tuser = {b_appl, b_touch};

    a_applied_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> o_m_tuser[0])
        else $error("impulse applied to a pair that is not touching");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result present right after reset");

endmodule

FILE: verif/ccimp_checker.sv
// ----------------------------------------------------------------------------
// ccimp_checker
// Watches the pair and velocity streams of the collision core, computes the
// expected impulse result for every accepted pair and compares each output
// transfer against the oldest pending prediction, field by field.
// ----------------------------------------------------------------------------
module ccimp_checker
    import ccimp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [OUT_TUSER_W-1:0] i_m_tuser,
    input  logic                   i_cfg_wr_en,
    input  logic [REST_W-1:0]      i_cfg_wr_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned CAP62 = (64'd1 << 62) - 64'd1;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] va_x;
        logic signed [WORD_BITS-1:0] va_y;
        logic signed [WORD_BITS-1:0] vb_x;
        logic signed [WORD_BITS-1:0] vb_y;
        logic                        touching;
        logic                        applied;
    } t_velocities;

    t_velocities      velocity_q[$];
    logic [REST_W-1:0] restitution_reg;
    int               fail_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = velocity_q.size();

    function automatic longint unsigned umag(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                  int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        return (p > {64'd0, CAP62}) ? CAP62 : p[63:0];
    endfunction

    function automatic longint smul_shift(longint a, longint b, int sh);
        longint m;
        m = longint'(mul_shift(umag(a), umag(b), sh));
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, bits;
        r = 0;
        bits = 64'd1 << 62;
        while (bits > x) bits = bits >> 2;
        while (bits != 0) begin
            if (x >= r + bits) begin
                x = x - (r + bits);
                r = (r >> 1) + bits;
            end else begin
                r = r >> 1;
            end
            bits = bits >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_normal(longint d, longint unsigned distance);
        longint unsigned m, q;
        m = umag(d);
        if (distance == 0) return 0;
        q = (m >= distance) ? (64'd1 << NORM_FRAC) : ((m << NORM_FRAC) / distance);
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [WORD_BITS-1:0] clamp_word(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[WORD_BITS-1:0];
    endfunction

    function automatic t_velocities collide(logic [IN_TDATA_W-1:0] d, logic skip,
                                            logic [REST_W-1:0] rest);
        t_velocities r;
        longint dx, dy, vax, vay, vbx, vby, nx, ny, dp, fa, fb, ka, kb;
        longint rax, ray, rbx, rby;
        longint unsigned ma, mb, cd, d2, distance, onepe, msum;
        logic touch, applied;
        dx  = longint'($signed(d[31:0]));
        dy  = longint'($signed(d[63:32]));
        vax = longint'($signed(d[95:64]));
        vay = longint'($signed(d[127:96]));
        vbx = longint'($signed(d[159:128]));
        vby = longint'($signed(d[191:160]));
        ma  = 64'(d[222:192]);
        mb  = 64'(d[253:223]);
        cd  = 64'(d[284:254]);
        rax = vax; ray = vay; rbx = vbx; rby = vby;
        applied = 1'b0;
        d2 = mul_shift(umag(dx), umag(dx), 0) + mul_shift(umag(dy), umag(dy), 0);
        touch = !skip && (d2 < mul_shift(cd, cd, 0));
        if (touch) begin
            distance = int_sqrt(d2);
            nx = unit_normal(dx, distance);
            ny = unit_normal(dy, distance);
            dp = smul_shift(vax - vbx, nx, NORM_FRAC) + smul_shift(vay - vby, ny, NORM_FRAC);
            if (dp <= 0) begin
                applied = 1'b1;
                onepe = (64'd1 << FRAC_BITS) + 64'(rest);
                msum = ma + mb;
                fa = 0;
                fb = 0;
                if (msum != 0) begin
                    fa = longint'(mul_shift(onepe, mb, 0) / msum);
                    fb = longint'(mul_shift(onepe, ma, 0) / msum);
                end
                ka = smul_shift(dp, fa, FRAC_BITS);
                kb = smul_shift(dp, fb, FRAC_BITS);
                rax = vax - smul_shift(nx, ka, NORM_FRAC);
                ray = vay - smul_shift(ny, ka, NORM_FRAC);
                rbx = vbx + smul_shift(nx, kb, NORM_FRAC);
                rby = vby + smul_shift(ny, kb, NORM_FRAC);
            end
        end
        r.va_x = clamp_word(rax);
        r.va_y = clamp_word(ray);
        r.vb_x = clamp_word(rbx);
        r.vb_y = clamp_word(rby);
        r.touching = touch;
        r.applied = applied;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_velocities exp_v;
        if (!i_rst_n) begin
            restitution_reg <= REST_RESET;
            fail_cnt <= 0;
            velocity_q.delete();
        end else begin
            if (i_cfg_wr_en) restitution_reg <= i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready)
                velocity_q.push_back(collide(i_s_tdata, i_s_tuser, restitution_reg));
            if (i_m_tvalid && i_m_tready) begin
                if (velocity_q.size() == 0) begin
                    $error("unexpected output transfer: tdata %h tuser %b",
                           i_m_tdata, i_m_tuser);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    exp_v = velocity_q.pop_front();
                    if ({exp_v.vb_y, exp_v.vb_x, exp_v.va_y, exp_v.va_x,
                         exp_v.applied, exp_v.touching} !== {i_m_tdata, i_m_tuser})
                        fail_cnt <= fail_cnt + 1;
                    if (exp_v.va_x !== i_m_tdata[31:0])
                        $error("new_vel_a_x: expected %h actual %h", exp_v.va_x,
                               i_m_tdata[31:0]);
                    if (exp_v.va_y !== i_m_tdata[63:32])
                        $error("new_vel_a_y: expected %h actual %h", exp_v.va_y,
                               i_m_tdata[63:32]);
                    if (exp_v.vb_x !== i_m_tdata[95:64])
                        $error("new_vel_b_x: expected %h actual %h", exp_v.vb_x,
                               i_m_tdata[95:64]);
                    if (exp_v.vb_y !== i_m_tdata[127:96])
                        $error("new_vel_b_y: expected %h actual %h", exp_v.vb_y,
                               i_m_tdata[127:96]);
                    if (exp_v.touching !== i_m_tuser[0])
                        $error("touching: expected %b actual %b", exp_v.touching,
                               i_m_tuser[0]);
                    if (exp_v.applied !== i_m_tuser[1])
                        $error("impulse_applied: expected %b actual %b", exp_v.applied,
                               i_m_tuser[1]);
                end
            end
        end
    end

endmodule

FILE: verif/tb_circle_collision_impulse_core.sv
// ----------------------------------------------------------------------------
// tb_circle_collision_impulse_core
// Drives body pairs into the collision core: a directed set of edge cases,
// then random contact, noise and extreme pairs under several restitution
// settings and flow-control phases. The checker module judges the outputs.
// ----------------------------------------------------------------------------
module tb_circle_collision_impulse_core;
    import ccimp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_wr_en;
    logic [REST_W-1:0]      cfg_wr_data;
    int                     fail_count;
    int                     pending;
    int                     send_idle_pct;
    int                     recv_stall_pct;
    int                     idle_cycles;
    int                     pairs_sent;

    circle_collision_impulse_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tuser     (m_tuser),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    ccimp_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_pair(logic signed [31:0] rx, logic signed [31:0] ry,
                             logic signed [31:0] vax, logic signed [31:0] vay,
                             logic signed [31:0] vbx, logic signed [31:0] vby,
                             logic [30:0] ma, logic [30:0] mb, logic [30:0] cd,
                             logic skip);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({cd, mb, ma, vby, vbx, vay, vax, ry, rx});
        s_tuser  <= skip;
        do @(posedge i_clk); while (!s_tready);
        pairs_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_restitution(logic [REST_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_pair;
        logic signed [31:0] rx, ry, vax, vay, vbx, vby;
        logic [30:0] ma, mb, cd;
        int mode, sh;
        mode = $urandom_range(0, 9);
        sh = $urandom_range(0, 28);
        vax = $signed($urandom()) >>> sh;
        vay = $signed($urandom()) >>> sh;
        vbx = $signed($urandom()) >>> sh;
        vby = $signed($urandom()) >>> sh;
        ma = 31'($urandom() >> $urandom_range(1, 30));
        mb = 31'($urandom() >> $urandom_range(1, 30));
        if (mode <= 6) begin
            cd = 31'($urandom() >> $urandom_range(1, 27));
            rx = $signed($urandom_range(0, cd)) - $signed(cd >> 1);
            ry = $signed($urandom_range(0, cd)) - $signed(cd >> 1);
        end else if (mode <= 8) begin
            rx = $urandom();
            ry = $urandom();
            vax = $urandom(); vay = $urandom(); vbx = $urandom(); vby = $urandom();
            ma = 31'($urandom());
            mb = 31'($urandom());
            cd = 31'($urandom());
        end else begin
            rx = pick_extreme() >>> $urandom_range(0, 31);
            ry = pick_extreme() >>> $urandom_range(0, 31);
            vax = pick_extreme(); vay = pick_extreme();
            vbx = pick_extreme(); vby = pick_extreme();
            ma = $urandom_range(0, 1) ? 31'h7fffffff : 31'd1;
            mb = $urandom_range(0, 1) ? 31'h7fffffff : 31'd1;
            cd = $urandom_range(0, 1) ? 31'h7fffffff : 31'($urandom());
        end
        if (ma == 0) ma = 31'd1;
        if (mb == 0) mb = 31'd1;
        send_pair(rx, ry, vax, vay, vbx, vby, ma, mb, cd, $urandom_range(0, 9) == 0);
    endtask

    initial begin
        logic [REST_W-1:0] rest_values [4];
        int idle_values [4];
        int stall_values [4];
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pairs_sent = 0;
        rest_values = '{17'd0, 17'h1ffff, 17'd65536, 17'($urandom())};
        idle_values = '{0, 78, 0, 17};
        stall_values = '{0, 0, 78, 17};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed pairs at reset restitution
        send_pair(0, 0, 32'sh10000, 0, 0, 0, 31'h10000, 31'h10000, 31'd1, 1'b0);
        send_pair(0, 0, 0, 0, 0, 0, 31'd1, 31'd1, 31'd0, 1'b0);
        send_pair(32'sh10000, 0, -32'sh10000, 0, 32'sh10000, 0,
                  31'h10000, 31'h10000, 31'h20000, 1'b0);
        send_pair(32'sh10000, 0, 32'sh10000, 0, -32'sh10000, 0,
                  31'h10000, 31'h10000, 31'h20000, 1'b0);
        send_pair(32'sh10000, 0, -32'sh10000, 0, 32'sh10000, 0,
                  31'h10000, 31'h10000, 31'h20000, 1'b1);
        send_pair(32'sh20000, 0, -32'sh10000, 0, 0, 0,
                  31'h10000, 31'h10000, 31'h20000, 1'b0);
        send_pair(-32'sh8000, 32'sh8000, 32'sh7fffffff, 32'sh80000000,
                  32'sh80000000, 32'sh7fffffff, 31'd1, 31'h7fffffff, 31'h7fffffff, 1'b0);
        send_pair(32'sh8000, -32'sh8000, 32'sh80000000, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 31'd1, 31'h7fffffff, 1'b0);
        send_pair(32'sh80000000, 32'sh80000000, 0, 0, 0, 0,
                  31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 1'b0);
        send_pair(32'sh7fffffff, 32'sh7fffffff, -32'sd1, -32'sd1, 32'sd1, 32'sd1,
                  31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 1'b0);
        send_pair(32'sh7fffffff, 0, 32'sh80000000, 0, 32'sh7fffffff, 0,
                  31'd1, 31'd1, 31'h7fffffff, 1'b0);
        send_pair(0, -32'sh4000, 0, 32'sh40000, 0, -32'sh40000,
                  31'h30000, 31'h8000, 31'h5000, 1'b0);
        send_pair(32'sh3000, 32'sh4000, -32'sh20000, -32'sh30000, 32'sh1000, 32'sh2000,
                  31'h18000, 31'h28000, 31'h5001, 1'b0);
        send_pair(32'sh3000, 32'sh4000, 0, 0, 0, 0, 31'h10000, 31'h10000, 31'h5001, 1'b0);
        send_pair(32'sh3000, 32'sh4000, 0, 0, 0, 0, 31'h10000, 31'h10000, 31'h5000, 1'b0);
        send_pair(-32'sd1, 32'sd1, 32'sd5, 32'sd5, 32'sd7, 32'sd3,
                  31'd1, 31'd1, 31'd2, 1'b0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_values[ph];
            recv_stall_pct = stall_values[ph];
            write_restitution(rest_values[ph]);
            for (int n = 0; n < 250; n++) begin
                random_pair();
                if (n == 120) drain();
            end
            drain();
        end
        write_restitution(REST_RESET);

        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("Sent %0d body pairs: edge cases, contact, noise and extreme pairs", pairs_sent);
        $display("over restitution 0, 1.0, max and random with four flow-control phases");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/ccimp_pkg.sv
src/ccimp_front.sv
src/ccimp_sqrt.sv
src/ccimp_div.sv
src/ccimp_back.sv
src/circle_collision_impulse_core.sv
verif/ccimp_checker.sv
verif/tb_circle_collision_impulse_core.sv
